[src/hsr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsr_pkg
// Shared widths, register indexes, reset values and table entry layout for the
// high-voltage setpoint ramp.
// ----------------------------------------------------------------------------
package hsr_pkg;

    localparam int CHAN_COUNT = 32;
    localparam int ADDR_W     = (CHAN_COUNT > 1) ? $clog2(CHAN_COUNT) : 1;

    localparam int CHAN_W    = 5;
    localparam int VOLT_W    = 24;
    localparam int RATE_W    = 20;
    localparam int TIME_W    = 32;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 24;

    // ramp step: floor(elapsed * rate / 1000), saturated to 2^24
    localparam int STEP_W    = 25;
    localparam int HALF_W    = TIME_W / 2;
    localparam int PPROD_W   = HALF_W + RATE_W;
    localparam int PROD_W    = TIME_W + RATE_W;

    // below the saturation point the product fits 34 bits, so product >> 3
    // fits 31 bits and floor(x / 125) = (x * RECIP_125) >> RECIP_SH exactly
    localparam int DIVX_W       = 31;
    localparam int RECIP_W      = 29;
    localparam int RECIP_SH     = 35;
    localparam int RECIP_PROD_W = DIVX_W + RECIP_W;

    localparam logic [RECIP_W-1:0] RECIP_125     = 29'd274_877_907;
    localparam logic [PROD_W-1:0]  STEP_SAT_PROD = 52'd16_777_217_000;
    localparam logic [STEP_W-1:0]  STEP_MAX      = 25'd16_777_216;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_VOLT_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_AWAY_RATE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TOWARD     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HW_RAMP    = 2'd3;

    localparam logic signed [VOLT_W-1:0] RST_VOLT_LIMIT = 24'sd100000;
    localparam logic [RATE_W-1:0]        RST_AWAY_RATE  = 20'd5000;
    localparam logic [RATE_W-1:0]        RST_TOWARD     = 20'd50000;

    // item kinds
    localparam logic MODE_DEMAND = 1'b0;
    localparam logic MODE_RAMP   = 1'b1;

    typedef struct packed {
        logic signed [VOLT_W-1:0] target;
        logic signed [VOLT_W-1:0] setpoint;
        logic [TIME_W-1:0]        ctime;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

[src/hv_setpoint_ramp_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hv_setpoint_ramp_core
// Per-channel high-voltage setpoint slew limiter with table state in RAM.
// ----------------------------------------------------------------------------
// Each item reads its channel entry (target, setpoint, change time) from one
// RAM, updates it and writes it back, giving one result per item. A demand
// item, a ramp tick that finds the setpoint at target, and a ramp tick with a
// zero rate go through the RAM read and then the update and write-back
// before the next item is taken. A ramp tick that moves the setpoint also
// waits for the step unit: the 32x20 multiply of elapsed time by rate in two
// partial products, their sum, and the saturation check with the division
// by 1000 done as a shift and a reciprocal multiply. Tables read as zero
// after reset through a valid bit per channel, so there is no clearing pass.
// A finished result waits in the output register while the next item is
// taken in.
// ----------------------------------------------------------------------------
module hv_setpoint_ramp_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration
    input  logic                              i_cfg_we,
    input  logic [hsr_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [hsr_pkg::CFG_W-1:0]         i_cfg_data,
    // items
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_mode,
    input  logic [hsr_pkg::CHAN_W-1:0]        i_chan,
    input  logic signed [hsr_pkg::VOLT_W-1:0] i_demand_mv,
    input  logic [hsr_pkg::TIME_W-1:0]        i_now_ms,
    // results
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [hsr_pkg::CHAN_W-1:0]        o_out_chan,
    output logic signed [hsr_pkg::VOLT_W-1:0] o_setpoint_mv,
    output logic                              o_drive_write,
    output logic signed [hsr_pkg::VOLT_W-1:0] o_target_mv
);
    import hsr_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_STEP = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    localparam int EXT_W = VOLT_W + 3;

    // configuration registers
    logic signed [VOLT_W-1:0] r_vlimit;
    logic [RATE_W-1:0]        r_away_rate;
    logic [RATE_W-1:0]        r_toward_rate;
    logic                     r_hw_ramp;

    logic [1:0]               r_state, n_state;
    logic [CHAN_COUNT-1:0]    r_valid;
    logic                     r_rd_vld;
    logic                     r_start;
    logic                     r_out_valid;

    // item being worked on
    logic                     r_mode;
    logic [CHAN_W-1:0]        r_chan;
    logic signed [VOLT_W-1:0] r_dem;
    logic [TIME_W-1:0]        r_now;

    // pending write-back
    logic signed [VOLT_W-1:0] r_t, r_s;
    logic [TIME_W-1:0]        r_ct;
    logic                     r_drive, r_we, r_up;
    logic [TIME_W-1:0]        r_elapsed;
    logic [RATE_W-1:0]        r_rate;

    logic [CHAN_W-1:0]        r_o_chan;
    logic signed [VOLT_W-1:0] r_o_setpoint, r_o_target;
    logic                     r_o_drive;

    logic                     accept, out_free, oor;
    logic [ENTRY_W-1:0]       ram_q;
    t_entry                   ent, wb_ent;

    logic signed [VOLT_W-1:0] dem_c;
    logic signed [VOLT_W-1:0] c_t, c_s;
    logic [TIME_W-1:0]        c_ct;
    logic                     c_drive, c_we, need_step, crossing;
    logic [RATE_W-1:0]        rate_sel;

    logic signed [VOLT_W-1:0] wb_t, wb_s;
    logic [TIME_W-1:0]        wb_ct;
    logic                     wb_drive, wb_we, cm_go;

    logic                     step_done;
    logic [STEP_W-1:0]        step;
    logic signed [EXT_W-1:0]  s_ext, t_ext, st_ext, mv_ext;
    logic signed [VOLT_W-1:0] ns;

    assign accept     = i_in_valid & ~o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign out_free   = ~r_out_valid | ~i_out_stall;
    assign oor        = ({{(32 - CHAN_W){1'b0}}, r_chan} >= 32'(CHAN_COUNT));

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vlimit      <= RST_VOLT_LIMIT;
            r_away_rate   <= RST_AWAY_RATE;
            r_toward_rate <= RST_TOWARD;
            r_hw_ramp     <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_VOLT_LIMIT: r_vlimit      <= i_cfg_data[VOLT_W-1:0];
                CFG_AWAY_RATE:  r_away_rate   <= i_cfg_data[RATE_W-1:0];
                CFG_TOWARD:     r_toward_rate <= i_cfg_data[RATE_W-1:0];
                CFG_HW_RAMP:    r_hw_ramp     <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // ---------------- channel table ----------------
    assign wb_ent.target   = wb_t;
    assign wb_ent.setpoint = wb_s;
    assign wb_ent.ctime    = wb_ct;

    hsr_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CHAN_COUNT)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (cm_go & wb_we & ~oor),
        .i_waddr (r_chan[ADDR_W-1:0]),
        .i_wdata (wb_ent),
        .i_re    (accept),
        .i_raddr (i_chan[ADDR_W-1:0]),
        .o_rdata (ram_q)
    );

    // never-written channels read as zero
    assign ent = r_rd_vld ? t_entry'(ram_q) : '0;

    // ---------------- update of the entry ----------------
    always_comb begin
        dem_c     = (r_dem > r_vlimit) ? r_vlimit : r_dem;
        c_t       = ent.target;
        c_s       = ent.setpoint;
        c_ct      = ent.ctime;
        c_drive   = 1'b0;
        c_we      = 1'b0;
        need_step = 1'b0;
        crossing  = 1'b0;
        rate_sel  = r_away_rate;

        if (ent.setpoint == '0) begin
            rate_sel = r_away_rate;
        end else if (ent.setpoint > 0) begin
            if (ent.target >= 0) begin
                rate_sel = (ent.target > ent.setpoint) ? r_away_rate : r_toward_rate;
            end else begin
                crossing = 1'b1;
                rate_sel = r_toward_rate;
            end
        end else begin
            if (ent.target >= 0) begin
                crossing = 1'b1;
                rate_sel = r_toward_rate;
            end else begin
                rate_sel = (ent.target > ent.setpoint) ? r_toward_rate : r_away_rate;
            end
        end

        if (r_mode == MODE_DEMAND) begin
            c_t  = dem_c;
            c_we = 1'b1;
            if (dem_c != ent.setpoint) begin
                c_ct = r_now;
                if (r_hw_ramp) begin
                    c_s     = dem_c;
                    c_drive = 1'b1;
                end
            end
        end else if (ent.target != ent.setpoint) begin
            if (rate_sel == '0) begin
                c_s     = crossing ? '0 : ent.target;
                c_ct    = r_now;
                c_drive = 1'b1;
                c_we    = 1'b1;
            end else begin
                need_step = 1'b1;
            end
        end
    end

    // ---------------- ramp move ----------------
    hsr_step u_step (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (r_start),
        .i_elapsed (r_elapsed),
        .i_rate    (r_rate),
        .o_done    (step_done),
        .o_step    (step)
    );

    always_comb begin
        s_ext  = EXT_W'(r_s);
        t_ext  = EXT_W'(r_t);
        st_ext = $signed({{(EXT_W - STEP_W){1'b0}}, step});
        ns     = r_t;
        if (r_up) begin
            mv_ext = s_ext + st_ext;
            if (mv_ext <= t_ext) ns = mv_ext[VOLT_W-1:0];
        end else begin
            mv_ext = s_ext - st_ext;
            if (mv_ext >= t_ext) ns = mv_ext[VOLT_W-1:0];
        end
    end

    // ---------------- write-back and result ----------------
    always_comb begin
        if (r_state == S_EXEC) begin
            wb_t     = c_t;
            wb_s     = c_s;
            wb_ct    = c_ct;
            wb_drive = c_drive;
            wb_we    = c_we;
        end else begin
            wb_t     = r_t;
            wb_s     = r_s;
            wb_ct    = r_ct;
            wb_drive = r_drive;
            wb_we    = r_we;
        end
        cm_go = out_free &
                (((r_state == S_EXEC) & ~need_step) | (r_state == S_FIN));
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (accept) n_state = S_EXEC;
            S_EXEC: begin
                if (need_step) begin
                    n_state = S_STEP;
                end else if (out_free) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_STEP: if (step_done) n_state = S_FIN;
            S_FIN:  if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_start     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_start <= (r_state == S_EXEC) & need_step;
            if (cm_go & wb_we & ~oor) begin
                r_valid[r_chan[ADDR_W-1:0]] <= 1'b1;
            end
            if (cm_go) begin
                r_out_valid <= 1'b1;
            end else if (~i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode   <= i_mode;
            r_chan   <= i_chan;
            r_dem    <= i_demand_mv;
            r_now    <= i_now_ms;
            r_rd_vld <= r_valid[i_chan[ADDR_W-1:0]];
        end
        if (r_state == S_EXEC) begin
            r_t       <= c_t;
            r_s       <= c_s;
            r_ct      <= c_ct;
            r_drive   <= c_drive;
            r_we      <= c_we;
            r_up      <= (ent.target > ent.setpoint);
            r_elapsed <= r_now - ent.ctime;
            r_rate    <= rate_sel;
        end else if ((r_state == S_STEP) & step_done) begin
            r_s     <= ns;
            r_ct    <= r_now;
            r_drive <= 1'b1;
            r_we    <= 1'b1;
        end
        if (cm_go) begin
            r_o_chan     <= r_chan;
            r_o_setpoint <= oor ? '0 : wb_s;
            r_o_target   <= oor ? '0 : wb_t;
            r_o_drive    <= ~oor & wb_drive;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_chan    = r_o_chan;
    assign o_setpoint_mv = r_o_setpoint;
    assign o_target_mv   = r_o_target;
    assign o_drive_write = r_o_drive;

endmodule

[src/hsr_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module hsr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[src/hsr_step.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsr_step
// Ramp step unit: elapsed * rate in two 16x20 partial products, then the
// saturation check and the division by 1000 as a shift and a reciprocal
// multiply.
// ----------------------------------------------------------------------------
module hsr_step (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [hsr_pkg::TIME_W-1:0]    i_elapsed,
    input  logic [hsr_pkg::RATE_W-1:0]    i_rate,
    output logic                          o_done,
    output logic [hsr_pkg::STEP_W-1:0]    o_step
);
    import hsr_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MLO  = 3'd1;
    localparam logic [2:0] ST_MHI  = 3'd2;
    localparam logic [2:0] ST_SUM  = 3'd3;
    localparam logic [2:0] ST_CHK  = 3'd4;
    localparam logic [2:0] ST_DONE = 3'd5;

    logic [2:0]              r_state, n_state;
    logic [TIME_W-1:0]       r_e;
    logic [RATE_W-1:0]       r_r;
    logic [PPROD_W-1:0]      r_plo, r_phi;
    logic [PROD_W-1:0]       r_prod;
    logic                    r_sat;
    logic [STEP_W-1:0]       r_quo;
    logic [RECIP_PROD_W-1:0] quo_prod;

    // floor(p / 1000) = floor((p >> 3) / 125); exact whenever the step is not saturated
    assign quo_prod = RECIP_PROD_W'(r_prod[DIVX_W+2:3]) * RECIP_PROD_W'(RECIP_125);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (i_start) n_state = ST_MLO;
            ST_MLO:  n_state = ST_MHI;
            ST_MHI:  n_state = ST_SUM;
            ST_SUM:  n_state = ST_CHK;
            ST_CHK:  n_state = ST_DONE;
            ST_DONE: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_e <= i_elapsed;
                r_r <= i_rate;
            end
            ST_MLO:  r_plo <= PPROD_W'(r_e[HALF_W-1:0]) * PPROD_W'(r_r);
            ST_MHI:  r_phi <= PPROD_W'(r_e[TIME_W-1:HALF_W]) * PPROD_W'(r_r);
            ST_SUM:  r_prod <= PROD_W'(r_plo) + {r_phi, {HALF_W{1'b0}}};
            ST_CHK: begin
                r_sat <= (r_prod >= STEP_SAT_PROD);
                r_quo <= quo_prod[RECIP_PROD_W-1:RECIP_SH];
            end
            default: ;
        endcase
    end

    assign o_done = (r_state == ST_DONE);
    assign o_step = r_sat ? STEP_MAX : r_quo;

endmodule
